### hw/rtl/lph_pkg.sv
`default_nettype none

package lph_pkg;

   localparam int KEY_IN_W = 16;
   localparam int SLOT_IDX_W = 4;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_FOUND    = 2'd2,
      ST_ABSENT   = 2'd3
   } status_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_SEARCH = 1'b1
   } op_type;

   typedef enum logic {
      PROBE_IDLE = 1'b0,
      PROBE_RUN  = 1'b1
   } probe_state_type;

   typedef struct packed {
      logic                  done;
      status_type            status;
      logic [SLOT_IDX_W-1:0] slot;
   } probe_result_type;

endpackage

`default_nettype wire

### hw/rtl/lph_home.sv
`default_nettype none

module lph_home import lph_pkg::*; #(
   parameter int SLOTS = 16,
   parameter int KEY_W = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     go_i,
   input  wire logic [KEY_W-1:0]         key_i,
   output logic                          done_o,
   output logic [$clog2(SLOTS)-1:0]      home_o
);

   localparam int PW = $clog2(SLOTS);
   localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);

   generate
      if (POW2) begin : g_mask
         localparam int XW = (KEY_W > PW) ? KEY_W : PW;
         logic [XW-1:0] key_ext;
         logic          done_ff;
         logic [PW-1:0] home_ff;

         assign key_ext = XW'(key_i);

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= go_i;
            end
         end

         always_ff @(posedge clock) begin
            if (go_i) begin
               home_ff <= key_ext[PW-1:0];
            end
         end

         assign done_o = done_ff;
         assign home_o = home_ff;
      end else begin : g_recip
         // quotient by reciprocal multiply is low by at most one,
         // so one compare and subtract gives the remainder
         localparam int RECIP = (1 << KEY_W) / SLOTS;
         localparam int PRW   = 2 * KEY_W;
         localparam int RW    = PW + 1;
         localparam int XW    = (KEY_W > RW) ? KEY_W : RW;
         logic [PRW-1:0] prod;
         logic [XW-1:0]  key_ext;
         logic [XW-1:0]  quo_ext;
         logic           run_ff;
         logic           done_ff;
         logic [RW-1:0]  key_lo_ff;
         logic [RW-1:0]  quo_lo_ff;
         logic [RW-1:0]  diff;
         logic [RW-1:0]  rem;
         logic [PW-1:0]  home_ff;

         assign prod    = PRW'(key_i) * PRW'(RECIP);
         assign key_ext = XW'(key_i);
         assign quo_ext = XW'(prod[PRW-1:KEY_W]);
         // the rough remainder is below 2*SLOTS, so the low bits are enough
         assign diff    = key_lo_ff - quo_lo_ff * RW'(SLOTS);
         assign rem     = (diff >= RW'(SLOTS)) ? diff - RW'(SLOTS) : diff;

         always_ff @(posedge clock) begin
            if (reset) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b0;
            end else begin
               run_ff  <= go_i;
               done_ff <= run_ff;
            end
         end

         always_ff @(posedge clock) begin
            if (go_i) begin
               key_lo_ff <= key_ext[RW-1:0];
               quo_lo_ff <= quo_ext[RW-1:0];
            end
            if (run_ff) begin
               home_ff <= rem[PW-1:0];
            end
         end

         assign done_o = done_ff;
         assign home_o = home_ff;
      end
   endgenerate

endmodule

`default_nettype wire

### hw/rtl/lph_probe.sv
`default_nettype none

module lph_probe import lph_pkg::*; #(
   parameter int SLOTS    = 16,
   parameter int KEY_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start_i,
   input  wire op_type                      op_i,
   input  wire logic [KEY_BITS-1:0]         key_i,
   input  wire logic [$clog2(SLOTS)-1:0]    home_i,
   output probe_result_type                 result_o
);

   localparam int PW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int SW = (PW > SLOT_IDX_W) ? PW : SLOT_IDX_W;

   probe_state_type state_ff, state_in;

   logic [KEY_BITS-1:0] slot_key_mem [SLOTS];
   logic [SLOTS-1:0]    valid_ff;

   logic [PW-1:0] pos_ff, pos_in;
   logic [CW-1:0] iss_ff, iss_in;
   logic          rd_live_ff, rd_live_in;
   logic          rd_last_ff, rd_last_in;
   logic [PW-1:0] rd_pos_ff;
   logic          rd_valid_ff;
   logic [KEY_BITS-1:0] rd_key_ff;

   logic          issue;
   logic          finish;
   logic          wr_en;
   logic          match;
   logic [SW-1:0] pos_ext;

   assign match   = rd_valid_ff && (rd_key_ff == key_i);
   assign pos_ext = SW'(rd_pos_ff);

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      iss_in     = iss_ff;
      rd_live_in = 1'b0;
      rd_last_in = rd_last_ff;
      issue      = 1'b0;
      finish     = 1'b0;
      wr_en      = 1'b0;
      result_o   = '{done: 1'b0, status: ST_ABSENT, slot: '0};

      case (state_ff)
         PROBE_IDLE: begin
            if (start_i) begin
               state_in = PROBE_RUN;
               pos_in   = home_i;
               iss_in   = '0;
            end
         end
         PROBE_RUN: begin
            // evaluate the slot read last cycle
            if (rd_live_ff) begin
               if (op_i == OP_INSERT) begin
                  if (!rd_valid_ff) begin
                     finish   = 1'b1;
                     wr_en    = 1'b1;
                     result_o = '{done: 1'b1, status: ST_INSERTED,
                                  slot: pos_ext[SLOT_IDX_W-1:0]};
                  end else if (rd_last_ff) begin
                     finish   = 1'b1;
                     result_o = '{done: 1'b1, status: ST_FULL, slot: '0};
                  end
               end else begin
                  if (!rd_valid_ff) begin
                     finish   = 1'b1;
                     result_o = '{done: 1'b1, status: ST_ABSENT, slot: '0};
                  end else if (match) begin
                     finish   = 1'b1;
                     result_o = '{done: 1'b1, status: ST_FOUND,
                                  slot: pos_ext[SLOT_IDX_W-1:0]};
                  end else if (rd_last_ff) begin
                     finish   = 1'b1;
                     result_o = '{done: 1'b1, status: ST_ABSENT, slot: '0};
                  end
               end
            end

            issue = !finish && (iss_ff != CW'(SLOTS));
            if (finish) begin
               state_in = PROBE_IDLE;
            end
            if (issue) begin
               rd_live_in = 1'b1;
               rd_last_in = (iss_ff == CW'(SLOTS - 1));
               iss_in     = iss_ff + 1'b1;
               pos_in     = (pos_ff == PW'(SLOTS - 1)) ? '0 : pos_ff + 1'b1;
            end
         end
         default: begin
            state_in = PROBE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= PROBE_IDLE;
         rd_live_ff <= 1'b0;
         valid_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         rd_live_ff <= rd_live_in;
         if (wr_en) begin
            valid_ff[rd_pos_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      iss_ff      <= iss_in;
      rd_last_ff  <= rd_last_in;
      rd_pos_ff   <= pos_ff;
      rd_valid_ff <= valid_ff[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_key_mem[rd_pos_ff] <= key_i;
      end
      rd_key_ff <= slot_key_mem[pos_ff];
   end

endmodule

`default_nettype wire

### hw/rtl/linear_probe_hash_table_core.sv
// Open-addressed hash table of SLOTS keys with linear probing. Pulse start while busy is
// low to issue an insert (req_operation 0) or a search (1); busy stays high until the
// result, which appears for exactly one cycle with rsp_strobe and cannot be held off.
// The home slot is computed first, from the low key bits when SLOTS is a power of two,
// otherwise by a reciprocal-multiply modulo unit; the probe then walks the key memory
// at one read per cycle, visiting 1 to SLOTS slots, and each read is registered before
// its slot is evaluated. A new request may be accepted in the cycle the result is shown.
`default_nettype none

module linear_probe_hash_table_core import lph_pkg::*; #(
   parameter int SLOTS    = 16,
   parameter int KEY_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_operation,
   input  wire logic [KEY_IN_W-1:0]   req_key,
   output logic                       rsp_strobe,
   output logic [1:0]                 rsp_status,
   output logic [SLOT_IDX_W-1:0]      rsp_slot_index
);

   localparam int PW  = $clog2(SLOTS);
   localparam int EFF = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
   localparam int KW  = (KEY_BITS > KEY_IN_W) ? KEY_BITS : KEY_IN_W;

   logic                  busy_ff;
   op_type                op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic                  rsp_strobe_ff;
   status_type            rsp_status_ff;
   logic [SLOT_IDX_W-1:0] rsp_slot_ff;

   logic                  accept;
   logic [KW-1:0]         key_ext;
   logic [KEY_BITS-1:0]   key_in;
   logic                  home_done;
   logic [PW-1:0]         home;
   probe_result_type      res;

   assign accept  = start && !busy_ff;
   assign key_ext = KW'(req_key);
   assign key_in  = key_ext[KEY_BITS-1:0];

   lph_home #(
      .SLOTS (SLOTS),
      .KEY_W (EFF)
   ) u_home (
      .clock  (clock),
      .reset  (reset),
      .go_i   (accept),
      .key_i  (key_in[EFF-1:0]),
      .done_o (home_done),
      .home_o (home)
   );

   lph_probe #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS)
   ) u_probe (
      .clock    (clock),
      .reset    (reset),
      .start_i  (home_done),
      .op_i     (op_ff),
      .key_i    (key_ff),
      .home_i   (home),
      .result_o (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= res.done;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (res.done) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= op_type'(req_operation);
         key_ff <= key_in;
      end
      if (res.done) begin
         rsp_status_ff <= res.status;
         rsp_slot_ff   <= res.slot;
      end
   end

   assign busy           = busy_ff;
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;

`ifndef SYNTHESIS
   a_no_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while a request is still in flight");

   a_done_only_in_flight: assert property (@(posedge clock) disable iff (reset)
      res.done |-> busy_ff)
      else $error("probe finished with no request in flight");

   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff && !rsp_strobe_ff)
      else $error("accepted item did not raise busy");

   a_miss_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == ST_FULL || rsp_status == ST_ABSENT)
      |-> rsp_slot_index == '0)
      else $error("slot index nonzero on full or not found");
`endif

endmodule

`default_nettype wire
